FILE: src/rect_region_subtract_defines.svh
// Assertion macros shared by the rectangle table RTL.
// Needs a clk and an arst_n in the scope that uses them.
`ifndef RECT_REGION_SUBTRACT_DEFINES_SVH
`define RECT_REGION_SUBTRACT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define RRS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define RRS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/rrs_pkg.sv
// Types and codes for the rectangle table block.
// No dependencies.
`timescale 1ns / 1ps

package rrs_pkg;

	localparam int COORD_W = 16;

	typedef enum logic [1:0] {
		K_ADD  = 2'd0,
		K_SUB  = 2'd1,
		K_READ = 2'd2,
		K_NONE = 2'd3
	} kind_t;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_NOIDX = 2'd1;
	localparam logic [1:0] STAT_OVF   = 2'd2;

	typedef struct packed {
		logic signed [COORD_W-1:0] l;
		logic signed [COORD_W-1:0] t;
		logic signed [COORD_W-1:0] r;
		logic signed [COORD_W-1:0] b;
	} box_t;

	typedef struct packed {
		logic [1:0]                kind;
		logic signed [COORD_W-1:0] in_left;
		logic signed [COORD_W-1:0] in_top;
		logic signed [COORD_W-1:0] in_right;
		logic signed [COORD_W-1:0] in_bottom;
		logic [5:0]                read_index;
	} item_t;

	typedef struct packed {
		logic [1:0]                status;
		logic [6:0]                entry_total;
		logic signed [COORD_W-1:0] out_left;
		logic signed [COORD_W-1:0] out_top;
		logic signed [COORD_W-1:0] out_right;
		logic signed [COORD_W-1:0] out_bottom;
	} result_t;

	// Outcome of testing one entry against the given rectangle.
	typedef struct packed {
		logic       replace;
		logic [2:0] np;
		box_t [3:0] pcs;
	} split_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD,
		S_RD,
		S_RDDATA,
		S_NEXT,
		S_FETCH,
		S_EVAL,
		S_SHRD,
		S_SHWR,
		S_PW,
		S_DONE
	} state_t;

endpackage

FILE: src/rect_region_subtract.sv
// Top level of the rectangle table: sequencer, table RAM and compare unit.
// Depends on rrs_pkg, rrs_ram, rrs_split and rect_region_subtract_defines.svh.
`timescale 1ns / 1ps

// Ordered table of up to MAX_RECTS rectangles with add, subtract and read
// words; each accepted word yields one result word, and one word is worked
// on at a time (item_ready is low while busy). The table lives in a RAM with
// one write and one registered read port. Subtract walks entries last to
// first: each entry is fetched and tested; for a replaced entry, each
// following entry is read and written to its new place (when the piece count
// is not one), then each piece is written.
// Edges are kept at COORD_BITS and sign-extended on read. The table needs
// no clearing after reset; only entries below entry_total can be read.
module rect_region_subtract #(
	parameter int MAX_RECTS  = 64,
	parameter int COORD_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  rrs_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output rrs_pkg::result_t result
);
	import rrs_pkg::*;
	`include "rect_region_subtract_defines.svh"

	localparam int AW = $clog2(MAX_RECTS);
	localparam int CW = $clog2(MAX_RECTS + 1);
	localparam int EW = 4 * COORD_BITS;

	state_t state_q, state_d;

	logic [1:0]    kind_q;
	box_t          g_q;
	logic [5:0]    idx_q;
	logic [CW-1:0] cnt_q, n_q, cnt_old_q;
	logic [AW-1:0] i_q, j_q;
	logic [2:0]    kept_q, k_q;
	logic signed [2:0] delta_q;
	box_t [3:0]    p_q;
	logic          drop_q, nf_q;
	box_t          edges_q;
	result_t       res_q;
	logic          out_valid_q;

	// RAM port
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [EW-1:0] ram_wdata, ram_rdata;
	box_t          wr_box, rd_box;

	split_t        split;

	logic signed [COORD_BITS-1:0] rl, rt, rr, rb;
	logic signed [COORD_BITS-1:0] il, it, ir, ib;

	// Evaluation arithmetic, widened so no sum wraps
	logic [CW:0]   cnt_w, i_w, j_w, free_w, np_w, cnt_new_w, dst_w, pw_w;
	logic [2:0]    kept_d;
	logic [AW+5:0] idx_w;
	logic [CW+6:0] total_w;
	logic          out_load;

	rrs_ram #(.WIDTH(EW), .DEPTH(MAX_RECTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	rrs_split u_split (
		.e   (rd_box),
		.g   (g_q),
		.res (split)
	);

	// Unpack the stored word and sign-extend each edge to full width.
	assign {rl, rt, rr, rb} = ram_rdata;
	assign rd_box = '{COORD_W'(rl), COORD_W'(rt), COORD_W'(rr), COORD_W'(rb)};
	assign ram_wdata = {wr_box.l[COORD_BITS-1:0], wr_box.t[COORD_BITS-1:0],
		wr_box.r[COORD_BITS-1:0], wr_box.b[COORD_BITS-1:0]};

	// Take the low COORD_BITS of each input edge.
	assign il = item.in_left[COORD_BITS-1:0];
	assign it = item.in_top[COORD_BITS-1:0];
	assign ir = item.in_right[COORD_BITS-1:0];
	assign ib = item.in_bottom[COORD_BITS-1:0];

	assign cnt_w  = (CW+1)'(cnt_q);
	assign i_w    = (CW+1)'(i_q);
	assign j_w    = (CW+1)'(j_q);
	assign np_w   = (CW+1)'(split.np);
	// Removing the entry frees one slot, so free is at least one.
	assign free_w = (CW+1)'(MAX_RECTS) - cnt_w + (CW+1)'(1);
	assign kept_d = (np_w > free_w) ? free_w[2:0] : split.np;
	assign cnt_new_w = cnt_w - (CW+1)'(1) + (CW+1)'(kept_d);
	assign dst_w  = j_w + (CW+1)'(delta_q);
	assign pw_w   = i_w + (CW+1)'(k_q);
	assign idx_w  = (AW+6)'(idx_q);
	assign total_w = (CW+7)'(cnt_q);

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = out_valid_q;
	assign result       = res_q;
	assign out_load     = (state_q == S_DONE) && (!out_valid_q || result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and RAM controls
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = i_q;
		ram_raddr = i_q;
		wr_box    = g_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					unique case (item.kind)
						K_ADD:   state_d = S_ADD;
						K_SUB:   state_d = S_NEXT;
						K_READ:  state_d = S_RD;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_ADD: begin
				ram_we    = (cnt_w < (CW+1)'(MAX_RECTS));
				ram_waddr = cnt_q[AW-1:0];
				state_d   = S_DONE;
			end
			S_RD: begin
				ram_raddr = idx_w[AW-1:0];
				if ((CW+6)'(idx_q) < (CW+6)'(cnt_q)
					&& (AW+6)'(idx_q) < (AW+6)'(MAX_RECTS)) begin
					state_d = S_RDDATA;
				end else begin
					state_d = S_DONE;
				end
			end
			S_RDDATA: state_d = S_DONE;
			S_NEXT:   state_d = (n_q == '0) ? S_DONE : S_FETCH;
			S_FETCH:  state_d = S_EVAL;
			S_EVAL: begin
				if (!split.replace) begin
					state_d = S_NEXT;
				end else if (kept_d != 3'd1 && i_w + (CW+1)'(1) < cnt_w) begin
					state_d = S_SHRD;
				end else if (kept_d != 3'd0) begin
					state_d = S_PW;
				end else begin
					state_d = S_NEXT;
				end
			end
			S_SHRD: begin
				ram_raddr = j_q;
				state_d   = S_SHWR;
			end
			S_SHWR: begin
				ram_we    = 1'b1;
				ram_waddr = dst_w[AW-1:0];
				wr_box    = rd_box;
				if (delta_q > 0) begin
					state_d = (j_w == i_w + (CW+1)'(1)) ? S_PW : S_SHRD;
				end else begin
					if (j_w == (CW+1)'(cnt_old_q) - (CW+1)'(1)) begin
						state_d = (kept_q != 3'd0) ? S_PW : S_NEXT;
					end else begin
						state_d = S_SHRD;
					end
				end
			end
			S_PW: begin
				// Pieces land in reverse order of insertion.
				ram_we    = 1'b1;
				ram_waddr = pw_w[AW-1:0];
				wr_box    = p_q[2'(kept_q - 3'd1 - k_q)];
				state_d   = (k_q == kept_q - 3'd1) ? S_NEXT : S_PW;
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Table count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_ADD && cnt_w < (CW+1)'(MAX_RECTS)) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (state_q == S_EVAL && split.replace) begin
				cnt_q <= cnt_new_w[CW-1:0];
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of the current word
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					kind_q  <= item.kind;
					g_q     <= '{COORD_W'(il), COORD_W'(it), COORD_W'(ir), COORD_W'(ib)};
					idx_q   <= item.read_index;
					n_q     <= cnt_q;
					drop_q  <= 1'b0;
					nf_q    <= 1'b0;
					edges_q <= '0;
				end
			end
			S_ADD: begin
				if (!(cnt_w < (CW+1)'(MAX_RECTS))) begin
					drop_q <= 1'b1;
				end
			end
			S_RD: begin
				if (!((CW+6)'(idx_q) < (CW+6)'(cnt_q)
					&& (AW+6)'(idx_q) < (AW+6)'(MAX_RECTS))) begin
					nf_q <= 1'b1;
				end
			end
			S_RDDATA: edges_q <= rd_box;
			S_NEXT: begin
				if (n_q != '0) begin
					i_q <= AW'(n_q - CW'(1));
					n_q <= n_q - CW'(1);
				end
			end
			S_EVAL: begin
				p_q       <= split.pcs;
				kept_q    <= kept_d;
				delta_q   <= signed'(kept_d) - 3'sd1;
				cnt_old_q <= cnt_q;
				k_q       <= '0;
				if (split.replace && kept_d != split.np) begin
					drop_q <= 1'b1;
				end
				// Move up from the top entry, or down from just above i.
				if (kept_d > 3'd1) begin
					j_q <= AW'(cnt_q - CW'(1));
				end else begin
					j_q <= AW'(i_w + (CW+1)'(1));
				end
			end
			S_SHWR: begin
				if (delta_q > 0) begin
					j_q <= j_q - AW'(1);
				end else begin
					j_q <= j_q + AW'(1);
				end
			end
			S_PW: k_q <= k_q + 3'd1;
			S_DONE: begin
				if (out_load) begin
					res_q.status      <= nf_q ? STAT_NOIDX : (drop_q ? STAT_OVF : STAT_OK);
					res_q.entry_total <= total_w[6:0];
					res_q.out_left    <= edges_q.l;
					res_q.out_top     <= edges_q.t;
					res_q.out_right   <= edges_q.r;
					res_q.out_bottom  <= edges_q.b;
				end
			end
			default: begin
			end
		endcase
	end

	`RRS_ASSERT(a_cnt_bound, (CW+1)'(cnt_q) <= (CW+1)'(MAX_RECTS), "entry count above capacity")
	`RRS_ASSERT(a_cnt_change, (cnt_q != $past(cnt_q)) |-> ($past(state_q) == S_ADD || $past(state_q) == S_EVAL), "count changed outside add or split")
	`RRS_ASSERT(a_wr_below, ram_we |-> ((CW+1)'(ram_waddr) < (CW+1)'(MAX_RECTS)), "table write out of range")
	`RRS_ASSERT(a_nf_read, (out_load && nf_q) |-> (kind_q == K_READ), "not-found status on a non-read word")

endmodule

FILE: src/rrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rrs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/rrs_split.sv
// Compare unit: classifies one entry against the given rectangle and forms
// its remaining pieces. Depends on rrs_pkg.
`timescale 1ns / 1ps

module rrs_split (
	input  rrs_pkg::box_t   e,
	input  rrs_pkg::box_t   g,
	output rrs_pkg::split_t res
);
	import rrs_pkg::*;

	always_comb begin
		res = '0;
		res.replace = 1'b1;
		if (g.l <= e.l && g.t <= e.t && g.r >= e.r && g.b >= e.b) begin
			res.np = 3'd0;
		end else if (g.r < e.l || g.b < e.t || g.t > e.b || g.l > e.r) begin
			res.replace = 1'b0;
		end else if (g.l <= e.l && g.r >= e.r && g.b < e.b && g.t <= e.t) begin
			res.pcs[0] = '{e.l, g.b, e.r, e.b}; res.np = 3'd1;
		end else if (g.t <= e.t && g.b >= e.b && g.r < e.r && g.l <= e.l) begin
			res.pcs[0] = '{g.r, e.t, e.r, e.b}; res.np = 3'd1;
		end else if (g.l <= e.l && g.r >= e.r && g.t > e.t && g.b >= e.b) begin
			res.pcs[0] = '{e.l, e.t, e.r, g.t}; res.np = 3'd1;
		end else if (g.t <= e.t && g.b >= e.b && g.l > e.l && g.r >= e.r) begin
			res.pcs[0] = '{e.l, e.t, g.l, e.b}; res.np = 3'd1;
		end else if (g.l <= e.l && g.t <= e.t && g.r < e.r && g.b < e.b) begin
			res.pcs[0] = '{g.r, e.t, e.r, g.b};
			res.pcs[1] = '{e.l, g.b, e.r, e.b}; res.np = 3'd2;
		end else if (g.l <= e.l && g.b >= e.b && g.r < e.r && g.t > e.t) begin
			res.pcs[0] = '{e.l, e.t, e.r, g.t};
			res.pcs[1] = '{g.r, g.t, e.r, e.b}; res.np = 3'd2;
		end else if (g.l > e.l && g.r >= e.r && g.t <= e.t && g.b < e.b) begin
			res.pcs[0] = '{e.l, e.t, g.l, e.b};
			res.pcs[1] = '{g.l, g.b, e.r, e.b}; res.np = 3'd2;
		end else if (g.l > e.l && g.r >= e.r && g.t > e.t && g.b >= e.b) begin
			res.pcs[0] = '{e.l, e.t, e.r, g.t};
			res.pcs[1] = '{e.l, g.t, g.l, e.b}; res.np = 3'd2;
		end else if (g.l > e.l && g.t <= e.t && g.r < e.r && g.b >= e.b) begin
			res.pcs[0] = '{e.l, e.t, g.l, e.b};
			res.pcs[1] = '{g.r, e.t, e.r, e.b}; res.np = 3'd2;
		end else if (g.l <= e.l && g.t > e.t && g.r >= e.r && g.b < e.b) begin
			res.pcs[0] = '{e.l, e.t, e.r, g.t};
			res.pcs[1] = '{e.l, g.b, e.r, e.b}; res.np = 3'd2;
		end else if (g.l > e.l && g.r < e.r && g.t <= e.t && g.b < e.b) begin
			res.pcs[0] = '{e.l, e.t, g.l, e.b};
			res.pcs[1] = '{g.l, g.b, g.r, e.b};
			res.pcs[2] = '{g.r, e.t, e.r, e.b}; res.np = 3'd3;
		end else if (g.t > e.t && g.b < e.b && g.l <= e.l && g.r < e.r) begin
			res.pcs[0] = '{e.l, e.t, e.r, g.t};
			res.pcs[1] = '{g.r, g.t, e.r, g.b};
			res.pcs[2] = '{e.l, g.b, e.r, e.b}; res.np = 3'd3;
		end else if (g.l > e.l && g.r < e.r && g.b >= e.b && g.t > e.t) begin
			res.pcs[0] = '{e.l, e.t, g.l, e.b};
			res.pcs[1] = '{g.l, e.t, g.r, g.t};
			res.pcs[2] = '{g.r, e.t, e.r, e.b}; res.np = 3'd3;
		end else if (g.t > e.t && g.b < e.b && g.r >= e.r && g.l > e.l) begin
			res.pcs[0] = '{e.l, e.t, e.r, g.t};
			res.pcs[1] = '{e.l, g.t, g.l, g.b};
			res.pcs[2] = '{e.l, g.b, e.r, e.b}; res.np = 3'd3;
		end else if (g.l > e.l && g.t > e.t && g.r < e.r && g.b < e.b) begin
			res.pcs[0] = '{e.l, e.t, e.r, g.t};
			res.pcs[1] = '{e.l, g.t, g.l, g.b};
			res.pcs[2] = '{e.l, g.b, e.r, e.b};
			res.pcs[3] = '{g.r, g.t, e.r, g.b}; res.np = 3'd4;
		end else begin
			// inverted edges fit no case: keep the entry
			res.replace = 1'b0;
		end
	end

endmodule
